// File: src/olid_pkg.sv
// Shared constants and types for the ordered list insert/delete core.
package olid_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 7;
    localparam int COUNT_OUT_W  = 8;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    // cells per registered read group
    localparam int GROUP_SIZE   = 16;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RSVD   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_FRONT,
        CELL_DELETE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// File: src/olid_cell.sv
// One list cell: holds a single entry and trades it with its neighbours.
module olid_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 8
) (
    input  logic                     aclk,
    input  olid_pkg::cell_op_t       op,
    input  logic [CW-1:0]            cnt,
    input  logic [CW-1:0]            pos,
    input  logic [olid_pkg::WORD_W-1:0] value,
    input  logic [olid_pkg::WORD_W-1:0] left,
    input  logic [olid_pkg::WORD_W-1:0] right,
    input  logic                     rd_en,
    output logic [olid_pkg::WORD_W-1:0] data_q,
    output logic [olid_pkg::WORD_W-1:0] rd_data
);
    import olid_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (op)
            CELL_APPEND: begin
                if (cnt == IDX) begin
                    data_next = value;
                end
            end
            CELL_FRONT: begin
                // shift up; the front cell takes the new word
                data_next = (INDEX == 0) ? value : left;
            end
            CELL_DELETE: begin
                if (IDX >= pos) begin
                    data_next = right;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q  = data_reg;
    assign rd_data = (rd_en && (pos == IDX)) ? data_reg : '0;

endmodule

// File: src/ordered_list_insert_delete_core.sv
// Ordered list insert/delete core: top level with the cell chain and control.
// A row of CAPACITY cells holds the list, one word per cell; every insert and
// delete moves all affected cells in parallel. Append, front insert, delete
// and any refused request land in the output register in the cycle after the
// input transaction. A successful read first passes through group registers:
// the cells are OR-reduced in groups of 16 into registers, and the group
// results are then combined into the output register. One request is in
// progress at a time; a new input transaction is taken whenever the control
// is idle and the output register is empty or being drained. The list needs
// no clearing pass after reset: of the list state, only the count is reset.
module ordered_list_insert_delete_core #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value[31:0], entry_count[39:32]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import olid_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
    localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NPAD   = NGROUP * GROUP_SIZE;

    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;

    assign kind     = s_tuser;
    assign value    = s_tdata[WORD_W-1:0];
    assign position = s_tdata[WORD_W+POS_W-1:WORD_W];

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [WORD_W-1:0]      rdval_reg, rdval_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;

    logic accept, full, pos_ok, rd_en;
    logic [CW-1:0] pos_idx;
    cell_op_t op;

    logic [WORD_W-1:0] cell_q  [CAPACITY];
    logic [WORD_W-1:0] rd_bus  [NPAD];
    logic [WORD_W-1:0] grp_or  [NGROUP];
    logic [WORD_W-1:0] grp_reg [NGROUP];
    logic [WORD_W-1:0] rd_final;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (cnt_reg == CW'(CAPACITY));
    assign pos_ok   = (CMP_W'(position) < CMP_W'(cnt_reg));
    // only used where pos_ok holds, so the narrowing never loses bits
    assign pos_idx  = CW'(position);
    assign rd_en    = accept && (kind == KIND_READ) && pos_ok;

    always_comb begin
        op = CELL_HOLD;
        if (accept) begin
            case (kind)
                KIND_APPEND: op = full ? CELL_HOLD : CELL_APPEND;
                KIND_FRONT:  op = full ? CELL_HOLD : CELL_FRONT;
                KIND_DELETE: op = pos_ok ? CELL_DELETE : CELL_HOLD;
                default:     op = CELL_HOLD;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < NPAD; i++) begin : g_cell
            if (i < CAPACITY) begin : g_live
                logic [WORD_W-1:0] left_w, right_w;
                if (i == 0) begin : g_first
                    assign left_w = '0;
                end else begin : g_inner_l
                    assign left_w = cell_q[i-1];
                end
                if (i == CAPACITY - 1) begin : g_last
                    assign right_w = '0;
                end else begin : g_inner_r
                    assign right_w = cell_q[i+1];
                end
                olid_cell #(
                    .INDEX (i),
                    .CW    (CW)
                ) u_cell (
                    .aclk    (aclk),
                    .op      (op),
                    .cnt     (cnt_reg),
                    .pos     (pos_idx),
                    .value   (value),
                    .left    (left_w),
                    .right   (right_w),
                    .rd_en   (rd_en),
                    .data_q  (cell_q[i]),
                    .rd_data (rd_bus[i])
                );
            end else begin : g_pad
                assign rd_bus[i] = '0;
            end
        end
    endgenerate

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_or[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                grp_or[g] = grp_or[g] | rd_bus[g*GROUP_SIZE + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int g = 0; g < NGROUP; g++) begin
                grp_reg[g] <= grp_or[g];
            end
        end
    end

    always_comb begin
        rd_final = '0;
        for (int g = 0; g < NGROUP; g++) begin
            rd_final = rd_final | grp_reg[g];
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        rdval_next   = rdval_reg;
        count_next   = count_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next = STATUS_DONE;
                    case (kind)
                        KIND_APPEND, KIND_FRONT: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        KIND_DELETE: begin
                            if (!pos_ok) begin
                                status_next = STATUS_BADPOS;
                            end else begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        default: begin
                            if (!pos_ok) begin
                                status_next = STATUS_BADPOS;
                            end
                        end
                    endcase
                    if (rd_en) begin
                        // hold the result until the group reduction settles
                        state_next = ST_READ;
                    end else begin
                        m_valid_next = 1'b1;
                        rdval_next   = '0;
                        count_next   = COUNT_OUT_W'(cnt_next);
                    end
                end
            end
            ST_READ: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    status_next  = STATUS_DONE;
                    rdval_next   = rd_final;
                    count_next   = COUNT_OUT_W'(cnt_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        count_reg  <= count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {count_reg, rdval_reg};
    assign m_tuser  = status_reg;

endmodule

// File: src/olid_checker.sv
// Port-level checker for the ordered list insert/delete core, with its bind.
module olid_checker #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import olid_pkg::*;

    localparam logic [COUNT_OUT_W-1:0] CAP8 = COUNT_OUT_W'(CAPACITY);

    // a stalled result transaction stays offered and unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != STATUS_RSVD)
        else $error("reserved status code");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_DONE |-> m_tdata[31:0] == 32'd0)
        else $error("refused request carries a read value");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[39:32] == CAP8)
        else $error("full status with a count below capacity");

    // no new request is taken while a result waits
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request taken while a result is stalled");

endmodule

bind ordered_list_insert_delete_core olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/olid_list_checker.sv
// Checker for the ordered list core: watches both channels, predicts each result, compares.
module olid_list_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // read_value[31:0], entry_count[39:32]
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          fail_count,
    output int          results_owed
);
    import olid_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [WORD_W-1:0]      read_value;
        logic [COUNT_OUT_W-1:0] entry_count;
    } list_answer_t;

    logic signed [WORD_W-1:0] shadow_words [CAPACITY_DEF];
    int unsigned              shadow_len;
    list_answer_t             owed_answers [$];
    int                       results_seen;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 results_seen, what, want, got);
        fail_count++;
    endtask

    // Apply one request to the shadow list and work out its answer.
    task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                                 input logic [POS_W-1:0] pos, output list_answer_t ans);
        int unsigned i;
        ans = '0;
        ans.status = STATUS_DONE;
        case (kind)
            KIND_APPEND: begin
                if (shadow_len >= CAPACITY_DEF) begin
                    ans.status = STATUS_FULL;
                end else begin
                    shadow_words[shadow_len] = value;
                    shadow_len++;
                end
            end
            KIND_FRONT: begin
                if (shadow_len >= CAPACITY_DEF) begin
                    ans.status = STATUS_FULL;
                end else begin
                    // shift held entries up one place, then drop the word in at the front
                    for (i = shadow_len; i > 0; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[0] = value;
                    shadow_len++;
                end
            end
            KIND_DELETE: begin
                if (pos >= shadow_len) begin
                    ans.status = STATUS_BADPOS;
                end else begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            default: begin
                if (pos >= shadow_len)
                    ans.status = STATUS_BADPOS;
                else
                    ans.read_value = shadow_words[pos];
            end
        endcase
        ans.entry_count = COUNT_OUT_W'(shadow_len);
    endtask

    task automatic check_answer(input list_answer_t got);
        list_answer_t want;
        if (owed_answers.size() == 0) begin
            report_mismatch("unexpected transaction", '0, 32'(got.status));
        end else begin
            want = owed_answers.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", want.read_value, got.read_value);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(want.entry_count),
                                32'(got.entry_count));
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        list_answer_t ans;
        list_answer_t got;
        if (!aresetn) begin
            shadow_len = 0;
            owed_answers.delete();
            results_seen = 0;
        end else begin
            // results always trail their request, so check before taking a new one
            if (m_tvalid && m_tready) begin
                got.status      = m_tuser;
                got.read_value  = m_tdata[31:0];
                got.entry_count = m_tdata[39:32];
                check_answer(got);
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[31:0], s_tdata[38:32], ans);
                owed_answers.push_back(ans);
            end
        end
        results_owed = owed_answers.size();
    end

endmodule

// File: dv/tb_ordered_list_insert_delete_core.sv
// Testbench top for the ordered list core: clock, reset, stimulus and verdict.
module tb_ordered_list_insert_delete_core;
    import olid_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT     = 15;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int          fail_count;
    int          results_owed;
    bit          steady;
    int unsigned list_len;
    int          requests_sent;
    int          kind_sent [4];
    int          times_full;
    int          times_empty;
    int          quiet_cycles;

    always #1 aclk = ~aclk;

    ordered_list_insert_delete_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    olid_list_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Abort when no transaction moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results owed",
                     quiet_cycles, results_owed);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a position inside the list, sometimes anything the field allows.
    function automatic logic [POS_W-1:0] rand_pos();
        if (list_len > 0 && $urandom_range(0, 9) < 8)
            return POS_W'($urandom_range(0, list_len - 1));
        return POS_W'($urandom_range(0, 127));
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, pos, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // track the length only to shape further stimulus
        case (kind)
            KIND_APPEND, KIND_FRONT: begin
                if (list_len < CAPACITY_DEF) begin
                    list_len++;
                    if (list_len == CAPACITY_DEF) times_full++;
                end
            end
            KIND_DELETE: begin
                if (pos < list_len) begin
                    list_len--;
                    if (list_len == 0) times_empty++;
                end
            end
            default: ;
        endcase
        kind_sent[kind]++;
        requests_sent++;
    endtask

    task automatic fill_list();
        while (list_len < CAPACITY_DEF) begin
            send_request($urandom_range(0, 1) ? KIND_FRONT : KIND_APPEND, rand_word(),
                         POS_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_request(KIND_READ, $urandom, rand_pos());
        end
        repeat (3) send_request($urandom_range(0, 1) ? KIND_FRONT : KIND_APPEND,
                                rand_word(), POS_W'($urandom));
        send_request(KIND_READ, $urandom, 7'd127);
        send_request(KIND_READ, $urandom, 7'd0);
        send_request(KIND_DELETE, $urandom, 7'd127);
        send_request(KIND_READ, $urandom, 7'd127);
    endtask

    task automatic drain_list();
        while (list_len > 0) begin
            send_request(KIND_DELETE, $urandom, POS_W'($urandom_range(0, list_len - 1)));
            if ($urandom_range(0, 5) == 0)
                send_request(KIND_READ, $urandom, rand_pos());
        end
        send_request(KIND_DELETE, $urandom, POS_W'($urandom));
        send_request(KIND_READ, $urandom, POS_W'($urandom));
    endtask

    task automatic mixed_requests();
        repeat ($urandom_range(20, 60))
            send_request(KIND_W'($urandom_range(0, 3)), rand_word(), rand_pos());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: every position is outside it
        send_request(KIND_READ,   $urandom, 7'd0);
        send_request(KIND_DELETE, $urandom, 7'd0);
        send_request(KIND_DELETE, $urandom, 7'd127);
        // extremes of the word, both insert kinds
        send_request(KIND_APPEND, 32'h7FFF_FFFF, 7'd127);
        send_request(KIND_APPEND, 32'h8000_0000, 7'd0);
        send_request(KIND_FRONT,  32'h0000_0000, 7'd127);
        send_request(KIND_FRONT,  32'hFFFF_FFFF, 7'd0);
        send_request(KIND_APPEND, 32'h0000_0001, POS_W'($urandom));
        send_request(KIND_READ,   $urandom, 7'd0);
        send_request(KIND_READ,   $urandom, 7'd4);
        send_request(KIND_READ,   $urandom, 7'd5);
        send_request(KIND_READ,   $urandom, 7'd127);
        // delete from the middle, the end and the front
        send_request(KIND_DELETE, $urandom, 7'd2);
        send_request(KIND_READ,   $urandom, 7'd2);
        send_request(KIND_DELETE, $urandom, 7'd3);
        send_request(KIND_READ,   $urandom, 7'd3);
        send_request(KIND_DELETE, $urandom, 7'd0);
        send_request(KIND_READ,   $urandom, 7'd0);
        send_request(KIND_READ,   $urandom, 7'd1);
        send_request(KIND_DELETE, $urandom, 7'd1);
        send_request(KIND_DELETE, $urandom, 7'd0);
        send_request(KIND_READ,   $urandom, 7'd0);

        while (requests_sent < RANDOM_ITEMS + 22) begin
            steady = (requests_sent >= 400 && requests_sent < 700);
            case ($urandom_range(0, 9))
                0, 1:    fill_list();
                2, 3:    drain_list();
                default: mixed_requests();
            endcase
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d appends, %0d front inserts, %0d deletes, %0d reads",
                 requests_sent, kind_sent[KIND_APPEND], kind_sent[KIND_FRONT],
                 kind_sent[KIND_DELETE], kind_sent[KIND_READ]);
        $display("List filled to capacity %0d times and emptied %0d times",
                 times_full, times_empty);
        if (fail_count == 0 && results_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
src/olid_pkg.sv
src/olid_cell.sv
src/ordered_list_insert_delete_core.sv
src/olid_checker.sv
dv/olid_list_checker.sv
dv/tb_ordered_list_insert_delete_core.sv
